>>> hw/rtl/saic_pkg.sv
// ----------------------------------------------------------------------------
// saic_pkg
// shared widths, codes and defaults of the set associative index cache
// ----------------------------------------------------------------------------
package saic_pkg;

    localparam int IDX_W    = 32;
    localparam int CFG_W    = 11;
    localparam int CNT_W    = 48;
    localparam int WAY_W    = 2;
    localparam int NWAY_W   = 3;
    localparam int ORD_W    = 8;
    localparam int DIV_BITS = 4;

    localparam int DEF_CACHE_WORDS = 1024;
    localparam int DEF_MAX_WAYS    = 4;

    localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [CFG_W-1:0] TOTAL_RESET = CFG_W'(1024);
    localparam logic [ORD_W-1:0] LRU_INIT    = 8'b11_10_01_00;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_DIRECT = 2'd1;
    localparam logic [1:0] MODE_TWO    = 2'd2;
    localparam logic [1:0] MODE_FOUR   = 2'd3;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_TOTAL = 1'b1;

    localparam logic ACT_CHECK = 1'b0;
    localparam logic ACT_ADD   = 1'b1;

endpackage

>>> hw/rtl/set_assoc_index_cache_lru.sv
// throughput: one transaction at a time, set by the line modulo unit
// (4 quotient bits per cycle) and one tag memory read per way
// reset: synchronous, active low; tag and lru memories are swept over all
// CACHE_WORDS entries after reset and after every configuration write, busy high
// results are strobed for one cycle and cannot be stalled
// ----------------------------------------------------------------------------
// set_assoc_index_cache_lru
// tag-only cache of vector indices, off or with 1, 2 or 4 ways (at most MAX_WAYS), and lru replacement
// ----------------------------------------------------------------------------
module set_assoc_index_cache_lru #(
    parameter int CACHE_WORDS = saic_pkg::DEF_CACHE_WORDS,
    parameter int MAX_WAYS    = saic_pkg::DEF_MAX_WAYS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_action,
    input  logic [saic_pkg::IDX_W-1:0]  i_vector_index,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic [saic_pkg::WAY_W-1:0]  o_way_used,
    output logic [saic_pkg::CNT_W-1:0]  o_hit_total,
    output logic [saic_pkg::CNT_W-1:0]  o_miss_total,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [saic_pkg::CFG_W-1:0]  i_cfg_wdata
);

    localparam int LINE_W  = $clog2(CACHE_WORDS + 1);
    localparam int ADDR_W  = $clog2(CACHE_WORDS);
    localparam int DIV_CYC = saic_pkg::IDX_W / saic_pkg::DIV_BITS;
    localparam int DCNT_W  = $clog2(DIV_CYC);
    localparam int RSH     = LINE_W + 2;
    localparam logic [RSH-1:0] RECIP3 = RSH'((2 ** RSH) / 3 + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_TAG_RD,
        S_TAG_CHK,
        S_ADD_RD,
        S_ADD_WR
    } t_state;

    typedef logic [saic_pkg::IDX_W:0] t_tag;

    t_state                          r_state;
    logic [ADDR_W-1:0]               r_clr;
    logic [1:0]                      r_mode;
    logic [saic_pkg::CFG_W-1:0]      r_total;
    logic [saic_pkg::NWAY_W-1:0]     r_n_ways;
    logic [LINE_W-1:0]               r_n_lines;
    logic                            r_action;
    logic [saic_pkg::IDX_W-1:0]      r_idx;
    logic [saic_pkg::IDX_W-1:0]      r_dvd;
    logic [LINE_W-1:0]               r_rem;
    logic [DCNT_W-1:0]               r_cnt;
    logic [ADDR_W-1:0]               r_line;
    logic [ADDR_W-1:0]               r_slot;
    logic [saic_pkg::WAY_W-1:0]      r_way;
    logic                            r_valid;
    logic                            r_hit;
    logic [saic_pkg::WAY_W-1:0]      r_way_out;
    logic [saic_pkg::CNT_W-1:0]      r_hit_cnt;
    logic [saic_pkg::CNT_W-1:0]      r_miss_cnt;
    t_tag                            r_tag_q;
    logic [saic_pkg::ORD_W-1:0]      r_lru_q;

    t_tag                            tag_mem [CACHE_WORDS];
    logic [saic_pkg::ORD_W-1:0]      lru_mem [CACHE_WORDS];

    logic [LINE_W-1:0]               words;
    logic [saic_pkg::NWAY_W-1:0]     mode_ways;
    logic [saic_pkg::NWAY_W-1:0]     n_ways;
    logic [LINE_W-1:0]               n_lines;
    logic [LINE_W+RSH-1:0]           prod3;
    logic [LINE_W-1:0]               rem_v;
    logic [LINE_W:0]                 trial;
    logic [LINE_W-1:0]               n_rem;
    logic                            tag_match;
    logic                            last_way;
    logic [saic_pkg::WAY_W-1:0]      victim;
    logic [LINE_W+1:0]               victim_off;
    logic [ADDR_W-1:0]               victim_slot;
    logic                            tag_we;
    logic [ADDR_W-1:0]               tag_waddr;
    t_tag                            tag_wdata;
    logic                            lru_we;
    logic [ADDR_W-1:0]               lru_waddr;
    logic [saic_pkg::ORD_W-1:0]      lru_wdata;

    function automatic logic [saic_pkg::ORD_W-1:0] f_make_recent(
        input logic [saic_pkg::ORD_W-1:0]  ord,
        input logic [saic_pkg::WAY_W-1:0]  way,
        input logic [saic_pkg::NWAY_W-1:0] nw
    );
        logic [saic_pkg::NWAY_W-1:0] pos;
        logic [saic_pkg::ORD_W-1:0]  res;
        pos = '0;
        for (int k = 0; k < 4; k++) begin
            if (k < int'(nw) && ord[2*k +: 2] == way) begin
                pos = saic_pkg::NWAY_W'(k);
            end
        end
        res = ord;
        for (int k = 0; k < 3; k++) begin
            if (k >= int'(pos) && k + 1 < int'(nw)) begin
                res[2*k +: 2] = ord[2*k+2 +: 2];
            end
        end
        for (int k = 0; k < 4; k++) begin
            if (k + 1 == int'(nw)) begin
                res[2*k +: 2] = way;
            end
        end
        return res;
    endfunction

    // geometry from the configuration registers
    always_comb begin
        if (32'(r_total) > 32'(CACHE_WORDS)) begin
            words = LINE_W'(CACHE_WORDS);
        end else begin
            words = LINE_W'(r_total);
        end
        unique case (r_mode)
            saic_pkg::MODE_OFF:    mode_ways = 3'd0;
            saic_pkg::MODE_DIRECT: mode_ways = 3'd1;
            saic_pkg::MODE_TWO:    mode_ways = 3'd2;
            saic_pkg::MODE_FOUR:   mode_ways = 3'd4;
        endcase
        if (32'(mode_ways) > 32'(MAX_WAYS)) begin
            n_ways = saic_pkg::NWAY_W'(MAX_WAYS);
        end else begin
            n_ways = mode_ways;
        end
        prod3 = (LINE_W+RSH)'(words) * (LINE_W+RSH)'(RECIP3);
        unique case (n_ways)
            3'd1:    n_lines = words;
            3'd2:    n_lines = words >> 1;
            3'd3:    n_lines = LINE_W'(prod3 >> RSH);
            3'd4:    n_lines = words >> 2;
            default: n_lines = '0;
        endcase
        if (n_ways != 3'd0 && n_lines == '0) begin
            n_lines = LINE_W'(1);
        end
    end

    // line modulo, several quotient bits per cycle
    always_comb begin
        rem_v = r_rem;
        trial = '0;
        for (int s = 0; s < saic_pkg::DIV_BITS; s++) begin
            trial = {rem_v, r_dvd[saic_pkg::IDX_W-1-s]};
            if (trial >= {1'b0, r_n_lines}) begin
                trial = trial - {1'b0, r_n_lines};
            end
            rem_v = trial[LINE_W-1:0];
        end
        n_rem = rem_v;
    end

    assign tag_match   = (r_tag_q == {1'b1, r_idx});
    assign last_way    = ({1'b0, r_way} == r_n_ways - 3'd1);
    assign victim      = r_lru_q[saic_pkg::WAY_W-1:0];
    assign victim_off  = (LINE_W+2)'(victim) * (LINE_W+2)'(r_n_lines);
    assign victim_slot = ADDR_W'(victim_off + (LINE_W+2)'(r_line));

    // memory write control
    always_comb begin
        tag_we    = 1'b0;
        tag_waddr = r_clr;
        tag_wdata = '0;
        lru_we    = 1'b0;
        lru_waddr = r_line;
        lru_wdata = f_make_recent(r_lru_q, r_way, r_n_ways);
        unique case (r_state)
            S_CLEAR: begin
                tag_we    = 1'b1;
                lru_we    = 1'b1;
                lru_waddr = r_clr;
                lru_wdata = saic_pkg::LRU_INIT;
            end
            S_TAG_CHK: begin
                lru_we = tag_match;
            end
            S_ADD_WR: begin
                tag_we    = 1'b1;
                tag_waddr = victim_slot;
                tag_wdata = {1'b1, r_idx};
                lru_we    = 1'b1;
                lru_wdata = f_make_recent(r_lru_q, victim, r_n_ways);
            end
            default: begin
                tag_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        r_tag_q <= tag_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (lru_we) begin
            lru_mem[lru_waddr] <= lru_wdata;
        end
        r_lru_q <= lru_mem[r_line];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_mode     <= saic_pkg::MODE_OFF;
            r_total    <= saic_pkg::TOTAL_RESET;
            r_n_ways   <= '0;
            r_n_lines  <= '0;
            r_valid    <= 1'b0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else begin
            r_valid   <= 1'b0;
            r_n_ways  <= n_ways;
            r_n_lines <= n_lines;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    saic_pkg::CFG_MODE:  r_mode  <= i_cfg_wdata[1:0];
                    saic_pkg::CFG_TOTAL: r_total <= i_cfg_wdata;
                endcase
                r_state <= S_CLEAR;
                r_clr   <= '0;
            end else begin
                unique case (r_state)
                    S_CLEAR: begin
                        r_clr <= r_clr + 1'b1;
                        if (r_clr == ADDR_W'(CACHE_WORDS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (start) begin
                            r_action <= i_action;
                            r_idx    <= i_vector_index;
                            r_dvd    <= i_vector_index;
                            r_rem    <= '0;
                            r_cnt    <= '0;
                            if (r_n_ways == 3'd0) begin
                                r_valid   <= 1'b1;
                                r_hit     <= 1'b0;
                                r_way_out <= '0;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                    end
                    S_DIV: begin
                        r_rem <= n_rem;
                        r_dvd <= r_dvd << saic_pkg::DIV_BITS;
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == DCNT_W'(DIV_CYC - 1)) begin
                            r_line <= ADDR_W'(n_rem);
                            r_slot <= ADDR_W'(n_rem);
                            r_way  <= '0;
                            if (r_action == saic_pkg::ACT_ADD) begin
                                r_state <= S_ADD_RD;
                            end else begin
                                r_state <= S_TAG_RD;
                            end
                        end
                    end
                    S_TAG_RD: begin
                        r_state <= S_TAG_CHK;
                    end
                    S_TAG_CHK: begin
                        priority if (tag_match) begin
                            if (r_hit_cnt != saic_pkg::CNT_MAX) begin
                                r_hit_cnt <= r_hit_cnt + 1'b1;
                            end
                            r_valid   <= 1'b1;
                            r_hit     <= 1'b1;
                            r_way_out <= r_way;
                            r_state   <= S_IDLE;
                        end else if (last_way) begin
                            if (r_miss_cnt != saic_pkg::CNT_MAX) begin
                                r_miss_cnt <= r_miss_cnt + 1'b1;
                            end
                            r_valid   <= 1'b1;
                            r_hit     <= 1'b0;
                            r_way_out <= '0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_way   <= r_way + 1'b1;
                            r_slot  <= ADDR_W'((LINE_W+1)'(r_slot) + (LINE_W+1)'(r_n_lines));
                            r_state <= S_TAG_RD;
                        end
                    end
                    S_ADD_RD: begin
                        r_state <= S_ADD_WR;
                    end
                    S_ADD_WR: begin
                        r_valid   <= 1'b1;
                        r_hit     <= 1'b0;
                        r_way_out <= victim;
                        r_state   <= S_IDLE;
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_hit        = r_hit;
    assign o_way_used   = r_way_out;
    assign o_hit_total  = r_hit_cnt;
    assign o_miss_total = r_miss_cnt;

`ifndef SYNTHESIS
    a_off_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_we && r_n_ways == 3'd0) |=> o_valid)
        else $error("off mode transaction gave no result");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(i_cfg_we)) |-> (r_state == S_IDLE))
        else $error("result strobed while not returning to idle");

    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (r_hit_cnt != '0))
        else $error("hit reported without a counted hit");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAG_RD) |-> (LINE_W'(r_line) < r_n_lines))
        else $error("line outside lines per way");
`endif

endmodule
